### hw/rtl/adsr_pkg.sv
package adsr_pkg;

    localparam int SAMPLE_RATE_DEF = 44100;
    localparam int PHASE_BITS_DEF  = 32;
    localparam int SINE_DEPTH_DEF  = 1024;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 7;
    localparam int SAMPLE_W  = 23;
    localparam int WAVE_W    = 17;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVEFORM = 3'd0,
        CFG_ATTACK   = 3'd1,
        CFG_DECAY    = 3'd2,
        CFG_SUSTAIN  = 3'd3,
        CFG_RELEASE  = 3'd4,
        CFG_PEAK     = 3'd5,
        CFG_KEY      = 3'd6
    } cfg_index_t;

    localparam logic [2:0] WAVE_SINE   = 3'd0;
    localparam logic [2:0] WAVE_TRI    = 3'd1;
    localparam logic [2:0] WAVE_SAW    = 3'd2;
    localparam logic [2:0] WAVE_PULSE  = 3'd3;
    localparam logic [2:0] WAVE_SILENT = 3'd4;

    function automatic logic [25:0] freq_q16(input logic [3:0] semi);
        logic [25:0] f;
        begin
            unique case (semi)
                4'd0:    f = 26'd28835840;
                4'd1:    f = 26'd30550524;
                4'd2:    f = 26'd32498188;
                4'd3:    f = 26'd34291778;
                4'd4:    f = 26'd36330865;
                4'd5:    f = 26'd38491259;
                4'd6:    f = 26'd40780038;
                4'd7:    f = 26'd43204936;
                4'd8:    f = 26'd45774012;
                4'd9:    f = 26'd48495919;
                4'd10:   f = 26'd51379634;
                4'd11:   f = 26'd54434791;
                default: f = 26'd0;
            endcase
            return f;
        end
    endfunction

endpackage

### hw/rtl/adsr_if.sv
interface adsr_cmd_if;
    import adsr_pkg::*;
    logic              valid;
    logic              ready;
    logic              gate;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;

    modport source (output valid, gate, note, velocity, input ready);
    modport sink   (input valid, gate, note, velocity, output ready);
endinterface

interface adsr_smp_if;
    import adsr_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       active;

    modport source (output valid, sample, active, input ready);
    modport sink   (input valid, sample, active, output ready);
endinterface

### hw/rtl/adsr_oscillator_voice.sv
// One synthesizer voice: each cmd transaction (gate, note, velocity) yields one smp
// transaction (sample, active). A rising gate restarts the note, a falling gate during a
// note starts the release, or silences the voice at once when the release is zero. All
// envelope and pitch divisions share one radix-4 serial divider: a sample needs none at
// full volume with zero attack, one in attack, decay or sustain, two in release, and one
// more on a rising gate for the phase increment, and it waits while smp.ready stays low.
// cmd.ready is high only while the voice waits for the next transaction; the user must
// write registers through wr_en/wr_index/wr_data only while idle; the block does not enforce it.
module adsr_oscillator_voice
    import adsr_pkg::*;
#(
    parameter int SAMPLE_RATE      = SAMPLE_RATE_DEF,
    parameter int PHASE_BITS       = PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    adsr_cmd_if.sink             cmd,
    adsr_smp_if.source           smp
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_INC_GO, ST_INC_WAIT, ST_ENV, ST_DIV1,
        ST_REL2, ST_DIV2, ST_MUL1, ST_MUL2, ST_OUT
    } state_t;

    typedef enum logic [1:0] {VP_IDLE, VP_NOTE, VP_REL} voice_t;

    typedef enum logic [2:0] {ENV_FULL, ENV_ATT, ENV_DEC, ENV_SUS, ENV_REL} env_t;

    logic [2:0]  waveform_reg;
    logic [15:0] attack_reg;
    logic [15:0] decay_reg;
    logic [6:0]  sustain_reg;
    logic [15:0] release_reg;
    logic [14:0] peak_reg;
    logic [3:0]  key_reg;

    state_t                    state_reg;
    voice_t                    voice_reg;
    env_t                      env_mode_reg;
    logic                      prev_gate_reg;
    logic [16:0]               npos_reg;
    logic [15:0]               rpos_reg;
    logic [PHASE_BITS-1:0]     phase_acc_reg;
    logic [PHASE_BITS-1:0]     phase_inc_reg;
    logic [VEL_W-1:0]          vel_reg;
    logic [NOTE_W-1:0]         note_reg;
    logic [21:0]               vs_reg;
    logic [21:0]               vc_reg;
    logic [14:0]               level_reg;
    logic [14:0]               env_reg;
    logic signed [32:0]        p1_reg;
    logic signed [40:0]        p2_reg;
    logic                      act_reg;
    logic                      out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                      active_reg;

    logic                      rise;
    logic                      fall;
    logic [15:0]               rpos_eff;
    voice_t                    voice_next;
    logic [6:0]                s_clip;
    env_t                      env_mode;
    logic [16:0]               ad_sum;
    logic [16:0]               x_minus_a;
    logic [14:0]               oct_mul;
    logic [3:0]                oct;
    logic [3:0]                semi;
    logic signed [7:0]         shamt;
    logic [DIV_NUM_W-1:0]      inc_num;
    logic                      div_start;
    logic [DIV_NUM_W-1:0]      div_num;
    logic [DIV_DEN_W-1:0]      div_den;
    logic                      div_done;
    logic [DIV_NUM_W-1:0]      div_quot;
    logic signed [WAVE_W-1:0]  wave;
    logic signed [40:0]        p2_adj;
    logic [15:0]               rpos_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg <= WAVE_SINE;
            attack_reg   <= '0;
            decay_reg    <= '0;
            sustain_reg  <= 7'd100;
            release_reg  <= '0;
            peak_reg     <= 15'd32767;
            key_reg      <= 4'd5;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_WAVEFORM: waveform_reg <= wr_data[2:0];
                CFG_ATTACK:   attack_reg   <= wr_data;
                CFG_DECAY:    decay_reg    <= wr_data;
                CFG_SUSTAIN:  sustain_reg  <= wr_data[6:0];
                CFG_RELEASE:  release_reg  <= wr_data;
                CFG_PEAK:     peak_reg     <= wr_data[14:0];
                CFG_KEY:      key_reg      <= wr_data[3:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        rise   = cmd.gate & ~prev_gate_reg;
        fall   = ~cmd.gate & prev_gate_reg;
        s_clip = (sustain_reg > 7'd100) ? 7'd100 : sustain_reg;
        rpos_eff   = rpos_reg;
        voice_next = voice_reg;
        if (rise)
            voice_next = VP_NOTE;
        else if (fall && voice_reg == VP_NOTE)
        begin
            rpos_eff   = '0;
            voice_next = (release_reg == '0) ? VP_IDLE : VP_REL;
        end
        if (voice_next == VP_REL && rpos_eff >= release_reg)
            voice_next = VP_IDLE;

        ad_sum    = {1'b0, attack_reg} + {1'b0, decay_reg};
        x_minus_a = npos_reg - {1'b0, attack_reg};
        if (voice_reg == VP_REL)
            env_mode = ENV_REL;
        else if (npos_reg < ad_sum)
        begin
            if (npos_reg <= {1'b0, attack_reg})
                env_mode = (attack_reg == '0) ? ENV_FULL : ENV_ATT;
            else
                env_mode = ENV_DEC;
        end
        else
            env_mode = ENV_SUS;

        oct_mul = 15'(note_reg * 8'd171);
        oct     = oct_mul[14:11];
        semi    = 4'(note_reg - 7'(oct * 4'd12));
        shamt   = 8'(PHASE_BITS - 24) + $signed({4'b0, oct}) + $signed({4'b0, key_reg});
        if (shamt >= 0)
            inc_num = DIV_NUM_W'(freq_q16(semi)) << shamt[5:0];
        else
            inc_num = DIV_NUM_W'(freq_q16(semi)) >> 6'(-shamt);
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            ST_INC_GO:
            begin
                div_start = 1'b1;
                div_num   = inc_num;
                div_den   = DIV_DEN_W'(SAMPLE_RATE);
            end
            ST_ENV:
            begin
                div_start = (env_mode != ENV_FULL);
                unique case (env_mode)
                    ENV_ATT:
                    begin
                        div_num = DIV_NUM_W'(npos_reg * peak_reg);
                        div_den = DIV_DEN_W'(attack_reg);
                    end
                    ENV_DEC:
                    begin
                        div_num = DIV_NUM_W'(x_minus_a[15:0] * vc_reg);
                        div_den = DIV_DEN_W'(decay_reg * 7'd100);
                    end
                    default:
                    begin
                        div_num = DIV_NUM_W'(vs_reg);
                        div_den = DIV_DEN_W'(7'd100);
                    end
                endcase
            end
            ST_REL2:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(rpos_reg * vs_reg);
                div_den   = DIV_DEN_W'(release_reg * 7'd100);
            end
            default: ;
        endcase
    end

    adsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    adsr_wave #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_wave (
        .clk      (clk),
        .acc      (phase_acc_reg),
        .waveform (waveform_reg),
        .wave     (wave)
    );

    assign p2_adj   = p2_reg + (p2_reg < 0 ? 41'sd32767 : 41'sd0);
    assign rpos_inc = (rpos_reg == 16'hFFFF) ? rpos_reg : rpos_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            voice_reg     <= VP_IDLE;
            env_mode_reg  <= ENV_FULL;
            prev_gate_reg <= 1'b0;
            npos_reg      <= '0;
            rpos_reg      <= '0;
            phase_acc_reg <= '0;
            phase_inc_reg <= '0;
            vel_reg       <= '0;
            act_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
            active_reg    <= 1'b0;
        end
        else
        begin
            if (smp.ready && state_reg != ST_OUT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        prev_gate_reg <= cmd.gate;
                        voice_reg     <= voice_next;
                        act_reg       <= (voice_next != VP_IDLE);
                        vs_reg        <= 22'(peak_reg * s_clip);
                        vc_reg        <= 22'(peak_reg * (7'd100 - s_clip));
                        if (rise)
                        begin
                            vel_reg       <= cmd.velocity;
                            note_reg      <= cmd.note;
                            phase_acc_reg <= '0;
                            npos_reg      <= '0;
                            rpos_reg      <= '0;
                        end
                        else if (fall && voice_reg == VP_NOTE)
                            rpos_reg <= '0;
                        if (voice_next == VP_IDLE)
                            state_reg <= ST_OUT;
                        else if (rise)
                            state_reg <= ST_INC_GO;
                        else
                            state_reg <= ST_ENV;
                    end
                end
                ST_INC_GO:
                    state_reg <= ST_INC_WAIT;
                ST_INC_WAIT:
                begin
                    if (div_done)
                    begin
                        phase_inc_reg <= div_quot[PHASE_BITS-1:0];
                        state_reg     <= ST_ENV;
                    end
                end
                ST_ENV:
                begin
                    env_mode_reg <= env_mode;
                    if (env_mode == ENV_FULL)
                    begin
                        env_reg   <= peak_reg;
                        state_reg <= ST_MUL1;
                    end
                    else
                        state_reg <= ST_DIV1;
                end
                ST_DIV1:
                begin
                    if (div_done)
                    begin
                        unique case (env_mode_reg)
                            ENV_DEC:
                            begin
                                env_reg   <= peak_reg - div_quot[14:0];
                                state_reg <= ST_MUL1;
                            end
                            ENV_REL:
                            begin
                                level_reg <= div_quot[14:0];
                                state_reg <= ST_REL2;
                            end
                            default:
                            begin
                                env_reg   <= div_quot[14:0];
                                state_reg <= ST_MUL1;
                            end
                        endcase
                    end
                end
                ST_REL2:
                    state_reg <= ST_DIV2;
                ST_DIV2:
                begin
                    if (div_done)
                    begin
                        env_reg   <= level_reg - div_quot[14:0];
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1:
                begin
                    p1_reg    <= $signed({1'b0, env_reg}) * wave;
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    p2_reg    <= p1_reg * $signed({1'b0, vel_reg});
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || smp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        active_reg    <= act_reg;
                        sample_reg    <= act_reg ? SAMPLE_W'(p2_adj >>> 15) : '0;
                        if (act_reg)
                        begin
                            phase_acc_reg <= phase_acc_reg + phase_inc_reg;
                            if (voice_reg == VP_NOTE)
                            begin
                                if (npos_reg != 17'h1FFFF)
                                    npos_reg <= npos_reg + 1'b1;
                            end
                            else
                            begin
                                rpos_reg <= rpos_inc;
                                if (rpos_inc >= release_reg)
                                    voice_reg <= VP_IDLE;
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign smp.valid  = out_valid_reg;
    assign smp.sample = sample_reg;
    assign smp.active = active_reg;

`ifndef SYNTHESIS
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_INC_WAIT || state_reg == ST_DIV1 ||
                      state_reg == ST_DIV2))
        else $error("divider finished outside a wait state");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("cmd accepted twice in a row");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        smp.valid && !smp.active |-> smp.sample == '0)
        else $error("inactive voice produced a nonzero sample");
`endif

endmodule

### hw/rtl/adsr_div.sv
module adsr_div
    import adsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quot
);

    localparam int STEPS = DIV_NUM_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W-1:0] rem_next;
    logic [DIV_NUM_W-1:0] quo_next;

    always_comb
    begin
        logic [DIV_DEN_W:0] t;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int k = 0; k < 2; k++)
        begin
            t = {rem_next, quo_next[DIV_NUM_W-1]};
            quo_next = {quo_next[DIV_NUM_W-2:0], 1'b0};
            if (t >= {1'b0, den_reg})
            begin
                t = t - {1'b0, den_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = t[DIV_DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

### hw/rtl/adsr_wave.sv
module adsr_wave
    import adsr_pkg::*;
#(
    parameter int PHASE_BITS       = PHASE_BITS_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic [PHASE_BITS-1:0]    acc,
    input  logic [2:0]               waveform,
    output logic signed [WAVE_W-1:0] wave
);

    localparam int LD    = $clog2(SINE_TABLE_DEPTH);
    localparam int POS_W = LD + 2;
    localparam int SH    = PHASE_BITS - POS_W;
    localparam int SHR   = (SH > 0) ? SH : 0;
    localparam int SHL   = (SH < 0) ? -SH : 0;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned SER_DIV [8] = '{1, 6, 20, 42, 72, 110, 156, 210};

    typedef logic [14:0] rom_t [SINE_TABLE_DEPTH+1];

    function automatic rom_t build_rom();
        rom_t              r;
        longint unsigned   a;
        longint unsigned   a2;
        longint unsigned   term;
        longint unsigned   v;
        longint            sum;
        begin
            for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
            begin
                a    = HALF_PI_Q30 * longint'(i) / SINE_TABLE_DEPTH;
                a2   = (a * a) >> 30;
                term = a;
                sum  = longint'(a);
                for (int k = 1; k <= 7; k++)
                begin
                    term = ((term * a2) >> 30) / SER_DIV[k];
                    if (k % 2 == 1)
                        sum = sum - longint'(term);
                    else
                        sum = sum + longint'(term);
                end
                if (sum < 0)
                    sum = 0;
                if (sum > (longint'(1) << 30))
                    sum = longint'(1) << 30;
                v = (longint'(sum) * 32767 + (longint'(1) << 29)) >> 30;
                if (v > 32767)
                    v = 32767;
                r[i] = 15'(v);
            end
            return r;
        end
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [PHASE_BITS+POS_W-1:0] wide;
    logic [POS_W-1:0]            pos;
    logic [LD:0]                 idx;
    logic [14:0]                 rom_reg;
    logic                        neg_reg;
    logic [PHASE_BITS+16:0]      tri_wide;
    logic [PHASE_BITS+15:0]      saw_wide;
    logic [16:0]                 u;
    logic [15:0]                 sv;
    logic signed [WAVE_W-1:0]    sine_w;
    logic signed [WAVE_W-1:0]    tri_w;
    logic signed [WAVE_W-1:0]    saw_w;
    logic signed [WAVE_W-1:0]    pulse_w;

    always_comb
    begin
        wide = (PHASE_BITS + POS_W)'(acc) << SHL;
        pos  = wide[SHR +: POS_W];
        if (pos[LD])
            idx = (LD+1)'(SINE_TABLE_DEPTH) - {1'b0, pos[LD-1:0]};
        else
            idx = {1'b0, pos[LD-1:0]};
    end

    always_ff @(posedge clk)
    begin
        rom_reg <= SINE_ROM[idx];
        neg_reg <= pos[POS_W-1];
    end

    always_comb
    begin
        sine_w   = neg_reg ? -$signed({2'b00, rom_reg}) : $signed({2'b00, rom_reg});
        tri_wide = {acc, 17'b0};
        u        = tri_wide[PHASE_BITS +: 17];
        if (u < 17'd32768)
            tri_w = $signed(u);
        else if (u > 17'd98304)
            tri_w = $signed(u);
        else
            tri_w = $signed(17'd65536 - u);
        saw_wide = {acc, 16'b0};
        sv       = saw_wide[PHASE_BITS +: 16];
        saw_w    = WAVE_W'($signed({~sv[15], sv[14:0]}));
        pulse_w  = acc[PHASE_BITS-1] ? -17'sd32768 : 17'sd32768;
        unique case (waveform)
            WAVE_SINE:  wave = sine_w;
            WAVE_TRI:   wave = tri_w;
            WAVE_SAW:   wave = saw_w;
            WAVE_PULSE: wave = pulse_w;
            default:    wave = '0;
        endcase
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import adsr_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int NUM_SETUPS  = 8;
    localparam int RAND_PER_SETUP = 192;

    typedef enum logic [1:0] {V_IDLE, V_NOTE, V_REL} voice_phase_t;

    typedef struct packed {
        logic              gate;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
    } key_event_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       active;
    } voice_out_t;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0] wr_data;

    adsr_cmd_if cmd_bus ();
    adsr_smp_if smp_bus ();

    adsr_oscillator_voice i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cmd      (cmd_bus),
        .smp      (smp_bus)
    );

    // voice model state and live registers
    logic [2:0]   m_wave;
    logic [15:0]  m_attack, m_decay, m_release;
    logic [6:0]   m_sustain;
    logic [14:0]  m_peak;
    logic [3:0]   m_key;
    logic [16:0]  m_note_pos;
    logic [15:0]  m_rel_pos;
    logic [31:0]  m_acc, m_inc;
    logic [6:0]   m_vel;
    voice_phase_t m_phase;
    logic         m_prev_gate;
    logic [15:0]  quarter_sine [0:1024];

    key_event_t   pending_events [$];
    voice_out_t   expected_samples [$];

    int  fail_count;
    int  events_sent;
    int  samples_seen;
    int  cycle_count;
    int  send_gap;
    int  drain_stall;
    bit  send_gaps_on;
    bit  drain_stalls_on;
    int  release_ends;
    key_event_t cur_event;

    function automatic void build_quarter_sine();
        longint unsigned a, a2, term, v;
        longint sum;
        for (int i = 0; i <= 1024; i++)
        begin
            a = 64'd1686629713 * i / 1024;
            a2 = (a * a) >> 30;
            term = a;
            sum = longint'(a);
            for (int k = 1; k <= 7; k++)
            begin
                term = ((term * a2) >> 30) / longint'((2 * k) * (2 * k + 1));
                if (k & 1)
                    sum -= longint'(term);
                else
                    sum += longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > (64'sd1 << 30))
                sum = 64'sd1 << 30;
            v = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
            if (v > 32767)
                v = 32767;
            quarter_sine[i] = v[15:0];
        end
    endfunction

    function automatic longint unsigned envelope_level();
        longint unsigned v, s, lvl, a, d, x;
        v = m_peak;
        s = (m_sustain > 100) ? 100 : m_sustain;
        lvl = v * s / 100;
        a = m_attack;
        d = m_decay;
        x = m_note_pos;
        if (m_phase == V_REL)
            return lvl - (v * s * m_rel_pos) / (100 * longint'(m_release));
        if (x < a + d)
        begin
            if (x <= a)
                return (a == 0) ? v : x * v / a;
            return v - ((x - a) * v * (100 - s)) / (d * 100);
        end
        return lvl;
    endfunction

    function automatic longint wave_level();
        longint unsigned acc, pos, quad, idx;
        longint u, w;
        acc = m_acc;
        case (m_wave)
            WAVE_SINE:
            begin
                pos = acc >> 20;
                quad = (pos / 1024) & 3;
                idx = pos % 1024;
                w = quad[0] ? quarter_sine[1024 - idx] : quarter_sine[idx];
                return quad[1] ? -w : w;
            end
            WAVE_TRI:
            begin
                u = longint'(acc >> 15);
                if (u < 32768)
                    return u;
                if (u > 98304)
                    return u - 131072;
                return 65536 - u;
            end
            WAVE_SAW:   return longint'(acc >> 16) - 32768;
            WAVE_PULSE: return m_acc[31] ? -32768 : 32768;
            default:    return 0;
        endcase
    endfunction

    function automatic voice_out_t voice_step(key_event_t ev);
        voice_out_t r;
        longint unsigned f, num;
        int sh;
        longint prod;
        r.sample = '0;
        r.active = 1'b0;
        if (ev.gate && !m_prev_gate)
        begin
            f = freq_q16(4'(ev.note % 12));
            sh = 16 + int'(ev.note / 12) + int'(m_key) - 8;
            num = f << sh;
            m_inc = 32'(num / 44100);
            m_vel = ev.velocity;
            m_acc = '0;
            m_note_pos = '0;
            m_rel_pos = '0;
            m_phase = V_NOTE;
        end
        else if (!ev.gate && m_prev_gate && m_phase == V_NOTE)
        begin
            m_rel_pos = '0;
            m_phase = (m_release == 0) ? V_IDLE : V_REL;
        end
        m_prev_gate = ev.gate;
        if (m_phase == V_REL && m_rel_pos >= m_release)
            m_phase = V_IDLE;
        if (m_phase != V_IDLE)
        begin
            prod = longint'(m_vel) * longint'(envelope_level()) * wave_level();
            r.sample = SAMPLE_W'(prod / 32768);
            r.active = 1'b1;
            m_acc = m_acc + m_inc;
            if (m_phase == V_NOTE)
            begin
                if (m_note_pos < 17'h1FFFF)
                    m_note_pos++;
            end
            else
            begin
                if (m_rel_pos < 16'hFFFF)
                    m_rel_pos++;
                if (m_rel_pos >= m_release)
                begin
                    m_phase = V_IDLE;
                    release_ends++;
                end
            end
        end
        return r;
    endfunction

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // cmd driver
    always @(posedge clk or negedge rst_n)
    begin
        logic next_valid;
        if (!rst_n)
        begin
            cmd_bus.valid <= 1'b0;
            cmd_bus.gate <= 1'b0;
            cmd_bus.note <= '0;
            cmd_bus.velocity <= '0;
            send_gap = 0;
        end
        else
        begin
            next_valid = cmd_bus.valid;
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                expected_samples.push_back(voice_step(cur_event));
                events_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_events.size() > 0)
                begin
                    cur_event = pending_events.pop_front();
                    cmd_bus.gate <= cur_event.gate;
                    cmd_bus.note <= cur_event.note;
                    cmd_bus.velocity <= cur_event.velocity;
                    next_valid = 1'b1;
                    send_gap = send_gaps_on ? $urandom_range(0, 7) : 0;
                end
            end
            cmd_bus.valid <= next_valid;
        end
    end

    // smp monitor
    always @(posedge clk or negedge rst_n)
    begin
        voice_out_t want;
        logic next_ready;
        if (!rst_n)
        begin
            smp_bus.ready <= 1'b0;
            drain_stall = 0;
        end
        else
        begin
            next_ready = smp_bus.ready;
            if (smp_bus.valid && smp_bus.ready)
            begin
                samples_seen++;
                if (expected_samples.size() == 0)
                begin
                    $error("unexpected transaction: sample %0d active %0b",
                           smp_bus.sample, smp_bus.active);
                    fail_count++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (smp_bus.sample !== want.sample)
                    begin
                        $error("sample: expected %0d, got %0d", want.sample, smp_bus.sample);
                        fail_count++;
                    end
                    if (smp_bus.active !== want.active)
                    begin
                        $error("active: expected %0b, got %0b", want.active, smp_bus.active);
                        fail_count++;
                    end
                end
                drain_stall = drain_stalls_on ? $urandom_range(0, 7) : 0;
            end
            if (drain_stall > 0)
            begin
                drain_stall--;
                next_ready = 1'b0;
            end
            else
                next_ready = 1'b1;
            smp_bus.ready <= next_ready;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d samples pending",
                     cycle_count, expected_samples.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(cfg_index_t idx, int unsigned val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val[CFG_W-1:0];
        case (idx)
            CFG_WAVEFORM: m_wave = val[2:0];
            CFG_ATTACK:   m_attack = val[15:0];
            CFG_DECAY:    m_decay = val[15:0];
            CFG_SUSTAIN:  m_sustain = val[6:0];
            CFG_RELEASE:  m_release = val[15:0];
            CFG_PEAK:     m_peak = val[14:0];
            CFG_KEY:      m_key = val[3:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_events.size() > 0 || cmd_bus.valid || expected_samples.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic void push_event(bit g, int n, int v);
        key_event_t ev;
        ev.gate = g;
        ev.note = n[NOTE_W-1:0];
        ev.velocity = v[VEL_W-1:0];
        pending_events.push_back(ev);
    endfunction

    function automatic int pick_note();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 95);
    endfunction

    task automatic queue_random_events(int count);
        int n, hold, tail, vel;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                hold = $urandom_range(1, 30);
                tail = $urandom_range(0, int'(m_release) > 40 ? 40 : int'(m_release) + 3);
                vel = $urandom_range(0, 127);
                push_event(1'b1, pick_note(), vel);
                for (int k = 0; k < hold; k++)
                    push_event(1'b1, pick_note(), $urandom_range(0, 127));
                for (int k = 0; k < tail; k++)
                    push_event(1'b0, pick_note(), $urandom_range(0, 127));
                n += 1 + hold + tail;
            end
            else
            begin
                push_event($urandom_range(0, 1), pick_note(), $urandom_range(0, 127));
                n++;
            end
        end
    endtask

    task automatic set_voice(int s);
        int unsigned atk, dec, sus, rel, pk, key;
        atk = (s == 1) ? 0 : (s == 3) ? 44100 : (s == 6) ? 65535 : $urandom_range(0, 30);
        dec = (s == 2) ? 0 : (s == 5) ? 44100 : (s == 7) ? 65535 : $urandom_range(0, 30);
        sus = (s == 2) ? 0 : (s == 3) ? 100 : (s == 4) ? 127 : $urandom_range(0, 100);
        rel = (s == 1) ? 0 : (s == 3) ? 44100 : (s == 6) ? 65535 : $urandom_range(1, 20);
        pk  = (s == 2) ? 0 : (s == 4 || s == 7) ? 32767 : $urandom_range(0, 32767);
        key = (s == 2) ? 0 : (s == 4) ? 15 : (s == 5) ? 9 : $urandom_range(0, 9);
        write_reg(CFG_WAVEFORM, s);
        write_reg(CFG_ATTACK, atk);
        write_reg(CFG_DECAY, dec);
        write_reg(CFG_SUSTAIN, sus);
        write_reg(CFG_RELEASE, rel);
        write_reg(CFG_PEAK, pk);
        write_reg(CFG_KEY, key);
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        fail_count = 0;
        events_sent = 0;
        samples_seen = 0;
        cycle_count = 0;
        release_ends = 0;
        send_gaps_on = 1'b0;
        drain_stalls_on = 1'b0;
        build_quarter_sine();
        m_wave = WAVE_SINE;
        m_attack = '0;
        m_decay = '0;
        m_sustain = 7'd100;
        m_release = '0;
        m_peak = 15'd32767;
        m_key = 4'd5;
        m_note_pos = '0;
        m_rel_pos = '0;
        m_acc = '0;
        m_inc = '0;
        m_vel = '0;
        m_phase = V_IDLE;
        m_prev_gate = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // idle, extremes of note and velocity, retrigger, instant silence on zero release
        push_event(1'b0, 0, 127);
        push_event(1'b1, 0, 127);
        push_event(1'b1, 127, 0);
        push_event(1'b1, 95, 0);
        push_event(1'b0, 1, 0);
        push_event(1'b0, 1, 0);
        push_event(1'b1, 127, 127);
        push_event(1'b1, 64, 85);
        push_event(1'b1, 0, 42);
        push_event(1'b0, 0, 0);
        push_event(1'b1, 95, 127);
        push_event(1'b1, 95, 127);
        push_event(1'b0, 95, 127);
        push_event(1'b1, 1, 1);
        push_event(1'b1, 1, 1);
        push_event(1'b0, 127, 127);
        wait_drained();
        set_voice(3);
        push_event(1'b1, 60, 127);
        push_event(1'b1, 60, 127);
        push_event(1'b0, 60, 127);
        push_event(1'b0, 60, 127);
        push_event(1'b1, 61, 100);
        push_event(1'b0, 61, 100);
        wait_drained();

        for (int s = 0; s < NUM_SETUPS; s++)
        begin
            set_voice(s);
            send_gaps_on = (s % 3) != 0;
            drain_stalls_on = (s % 3) != 1;
            queue_random_events(RAND_PER_SETUP);
            wait_drained();
        end

        $display("sent %0d key events, checked %0d samples, %0d releases ran out",
                 events_sent, samples_seen, release_ends);
        $display("covered all eight waveform codes and attack/decay/release extremes");
        if (fail_count == 0 && expected_samples.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
hw/rtl/adsr_pkg.sv
hw/rtl/adsr_if.sv
hw/rtl/adsr_div.sv
hw/rtl/adsr_wave.sv
hw/rtl/adsr_oscillator_voice.sv
verif/tb_top.sv
